@@ hw/rtl/psr_pkg.sv @@
// Shared types, widths and constants for the pedal speed ramp controller.
package psr_pkg;

  // Field widths
  localparam int unsigned RawW    = 10;
  localparam int unsigned SpeedW  = 24;
  localparam int unsigned GainW   = 24;
  localparam int unsigned ThrW    = 10;
  localparam int unsigned DzW     = 8;
  localparam int unsigned PotW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  // Datapath widths: shared multiplier operands, wide products and accumulator
  localparam int unsigned MulAW  = 24;
  localparam int unsigned MulBW  = 17;
  localparam int unsigned MulPW  = MulAW + MulBW;
  localparam int unsigned WideW  = 34;
  localparam int unsigned AccW   = 58;

  // Speed limits, Q8.16
  localparam logic [SpeedW-1:0] SpeedMax  = 24'hFF0000;
  localparam logic [SpeedW-1:0] SnapDelta = 24'd655;
  localparam logic [WideW-1:0]  DivConst  = 34'd1023;

  // Register defaults
  localparam logic [GainW-1:0] AccelGainRst  = 24'd279620;
  localparam logic [GainW-1:0] CoastGainRst  = 24'd559;
  localparam logic [GainW-1:0] BrakeGainRst  = 24'd55924;
  localparam logic [ThrW-1:0]  BrakeThrRst   = 10'd21;
  localparam logic [DzW-1:0]   DeadzoneLoRst = 8'd3;
  localparam logic [DzW-1:0]   DeadzoneHiRst = 8'd253;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_GAIN      = 3'd0,
    CFG_COAST_GAIN      = 3'd1,
    CFG_BRAKE_GAIN      = 3'd2,
    CFG_BRAKE_THRESHOLD = 3'd3,
    CFG_DEADZONE_LOW    = 3'd4,
    CFG_DEADZONE_HIGH   = 3'd5
  } cfg_idx_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DIV_A,
    ST_DIV_B,
    ST_DELTA,
    ST_MUL_K,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_UPDATE,
    ST_OUT
  } state_e;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_M,
    OP_DIV_A,
    OP_DIV_B,
    OP_DELTA,
    OP_MUL_K,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_UPDATE,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } psr_cmd_t;

  typedef struct packed {
    logic brake;
  } psr_status_t;

  typedef struct packed {
    logic [GainW-1:0] accel_gain;
    logic [GainW-1:0] coast_gain;
    logic [GainW-1:0] brake_gain;
    logic [ThrW-1:0]  brake_thr;
    logic [DzW-1:0]   dz_low;
    logic [DzW-1:0]   dz_high;
  } psr_cfg_t;

endpackage

@@ hw/rtl/psr_cfg.sv @@
// Configuration register bank: gains, brake threshold and deadzones.
module psr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [psr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psr_pkg::CfgDatW-1:0]  cfg_data_i,
  output psr_pkg::psr_cfg_t            cfg_o
);

  psr_pkg::psr_cfg_t cfg_q, cfg_d;

  // Always ready: a write is registered straight into the bank
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (psr_pkg::cfg_idx_e'(cfg_index_i))
        psr_pkg::CFG_ACCEL_GAIN:      cfg_d.accel_gain = cfg_data_i[psr_pkg::GainW-1:0];
        psr_pkg::CFG_COAST_GAIN:      cfg_d.coast_gain = cfg_data_i[psr_pkg::GainW-1:0];
        psr_pkg::CFG_BRAKE_GAIN:      cfg_d.brake_gain = cfg_data_i[psr_pkg::GainW-1:0];
        psr_pkg::CFG_BRAKE_THRESHOLD: cfg_d.brake_thr  = cfg_data_i[psr_pkg::ThrW-1:0];
        psr_pkg::CFG_DEADZONE_LOW:    cfg_d.dz_low     = cfg_data_i[psr_pkg::DzW-1:0];
        psr_pkg::CFG_DEADZONE_HIGH:   cfg_d.dz_high    = cfg_data_i[psr_pkg::DzW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_gain <= psr_pkg::AccelGainRst;
      cfg_q.coast_gain <= psr_pkg::CoastGainRst;
      cfg_q.brake_gain <= psr_pkg::BrakeGainRst;
      cfg_q.brake_thr  <= psr_pkg::BrakeThrRst;
      cfg_q.dz_low     <= psr_pkg::DeadzoneLoRst;
      cfg_q.dz_high    <= psr_pkg::DeadzoneHiRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

@@ hw/rtl/psr_dp.sv @@
// Datapath: speed state, shared 24x17 multiplier, divide by 1023 and output mapping.
module psr_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psr_pkg::psr_cmd_t            cmd_i,
  output psr_pkg::psr_status_t         status_o,
  input  psr_pkg::psr_cfg_t            cfg_i,
  input  logic [psr_pkg::RawW-1:0]     accel_raw_i,
  input  logic [psr_pkg::RawW-1:0]     brake_raw_i,
  input  logic [psr_pkg::RawW-1:0]     elapsed_ms_i,
  output logic [psr_pkg::PotW-1:0]     pot_value_o,
  output logic [psr_pkg::SpeedW-1:0]   speed_now_o
);

  localparam int unsigned SW = psr_pkg::SpeedW;
  localparam int unsigned WW = psr_pkg::WideW;

  // State and working registers
  logic [SW-1:0]               speed_q;
  logic [psr_pkg::RawW-1:0]    depth_b_q;
  logic [psr_pkg::RawW-1:0]    ms_q;
  logic                        brake_q, up_q, snap_q;
  logic [WW-1:0]               x_q;
  logic [SW-1:0]               q0_q;
  logic [SW-1:0]               div_q;
  logic [SW-1:0]               v_q;
  logic [WW-1:0]               k_q;
  logic [psr_pkg::AccW-1:0]    acc_q;
  logic [psr_pkg::PotW-1:0]    pot_q;
  logic [SW-1:0]               spd_out_q;

  // Load-time decode
  logic [psr_pkg::RawW-1:0] depth_a, depth_b;
  logic [17:0]              tgt255;
  logic [WW-1:0]            target_x;
  logic                     brake_now;

  assign depth_a   = ~accel_raw_i;
  assign depth_b   = ~brake_raw_i;
  assign tgt255    = {depth_a, 8'b0} - {8'b0, depth_a};
  assign target_x  = {tgt255, 16'b0};
  assign brake_now = (depth_b >= cfg_i.brake_thr) && (speed_q != '0);

  assign status_o.brake = brake_q;

  // Shared multiplier operand selection
  logic [psr_pkg::MulAW-1:0] mul_a;
  logic [psr_pkg::MulBW-1:0] mul_b;
  logic [psr_pkg::MulPW-1:0] mul_p;
  logic [psr_pkg::GainW-1:0] gain_sel;

  assign gain_sel = brake_q ? cfg_i.brake_gain : (up_q ? cfg_i.accel_gain : cfg_i.coast_gain);

  always_comb begin
    unique case (cmd_i.op)
      psr_pkg::OP_MUL_M: begin
        mul_a = speed_q;
        mul_b = {7'b0, depth_b_q};
      end
      psr_pkg::OP_MUL_K: begin
        mul_a = gain_sel;
        mul_b = {7'b0, ms_q};
      end
      psr_pkg::OP_MUL_LO: begin
        mul_a = v_q;
        mul_b = k_q[16:0];
      end
      psr_pkg::OP_MUL_HI: begin
        mul_a = v_q;
        mul_b = k_q[33:17];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{psr_pkg::MulBW{1'b0}}, mul_a} * {{psr_pkg::MulAW{1'b0}}, mul_b};

  // Divide by 1023: series estimate, then one correction step
  logic [WW:0]   div_sum;
  logic [WW-1:0] q0_x1023, div_rem;
  logic          div_fix;
  logic [SW-1:0] div_res;

  assign div_sum  = {1'b0, x_q} + {11'b0, x_q[33:10]} + {21'b0, x_q[33:20]}
                  + {31'b0, x_q[33:30]};
  assign q0_x1023 = {q0_q, 10'b0} - {10'b0, q0_q};
  assign div_rem  = x_q - q0_x1023;
  assign div_fix  = div_rem >= psr_pkg::DivConst;
  assign div_res  = q0_q + {23'b0, div_fix};

  // Distance to target
  logic          up_now;
  logic [SW-1:0] diff;

  assign up_now = div_q > speed_q;
  assign diff   = up_now ? (div_q - speed_q) : (speed_q - div_q);

  // Speed update with saturation at both ends
  logic [WW-1:0] step;
  logic [SW-1:0] dec_res, inc_res, next_speed;
  logic [WW:0]   inc_sum;

  assign step    = acc_q[psr_pkg::AccW-1:24];
  assign dec_res = (step >= {10'b0, speed_q}) ? '0 : (speed_q - step[SW-1:0]);
  assign inc_sum = {11'b0, speed_q} + {1'b0, step};
  assign inc_res = (inc_sum > {11'b0, psr_pkg::SpeedMax}) ? psr_pkg::SpeedMax
                                                          : inc_sum[SW-1:0];

  always_comb begin
    priority if (brake_q) begin
      next_speed = dec_res;
    end else if (snap_q) begin
      next_speed = div_q;
    end else if (up_q) begin
      next_speed = inc_res;
    end else begin
      next_speed = dec_res;
    end
  end

  // Deadzone, round up and invert into the wiper byte
  logic [7:0]    whole;
  logic [SW:0]   ceil_sum;
  logic [8:0]    ceil_val;
  logic [7:0]    out_val;

  assign whole    = speed_q[23:16];
  assign ceil_sum = {1'b0, speed_q} + 25'h00FFFF;
  assign ceil_val = ceil_sum[SW:16];

  always_comb begin
    priority if (whole > cfg_i.dz_high ||
                 (whole == cfg_i.dz_high && speed_q[15:0] != 16'b0)) begin
      out_val = 8'hFF;
    end else if (speed_q < {cfg_i.dz_low, 16'b0}) begin
      out_val = 8'h00;
    end else if (ceil_val > 9'd255) begin
      out_val = 8'hFF;
    end else begin
      out_val = ceil_val[7:0];
    end
  end

  // Speed state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (cmd_i.op == psr_pkg::OP_UPDATE) begin
      speed_q <= next_speed;
    end
  end

  // Working registers, advanced by the controller's commands
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      psr_pkg::OP_LOAD: begin
        depth_b_q <= depth_b;
        ms_q      <= elapsed_ms_i;
        brake_q   <= brake_now;
        x_q       <= target_x;
      end
      psr_pkg::OP_MUL_M:  x_q  <= mul_p[WW-1:0];
      psr_pkg::OP_DIV_A:  q0_q <= div_sum[33:10];
      psr_pkg::OP_DIV_B: begin
        div_q <= div_res;
        if (brake_q) begin
          v_q <= div_res;
        end
      end
      psr_pkg::OP_DELTA: begin
        up_q   <= up_now;
        v_q    <= diff;
        snap_q <= diff <= psr_pkg::SnapDelta;
      end
      psr_pkg::OP_MUL_K:  k_q   <= mul_p[WW-1:0];
      psr_pkg::OP_MUL_LO: acc_q <= {17'b0, mul_p};
      psr_pkg::OP_MUL_HI: acc_q <= acc_q + {mul_p, 17'b0};
      psr_pkg::OP_OUT: begin
        pot_q     <= 8'hFF - out_val;
        spd_out_q <= speed_q;
      end
      default: ;
    endcase
  end

  assign pot_value_o = pot_q;
  assign speed_now_o = spd_out_q;

endmodule

@@ hw/rtl/psr_ctrl.sv @@
// Controller: sequences the datapath per transaction and owns the handshakes.
module psr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  psr_pkg::psr_status_t  status_i,
  output psr_pkg::psr_cmd_t     cmd_o
);

  psr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  // Next state and datapath command
  always_comb begin
    state_d     = state_q;
    cmd_o.op    = psr_pkg::OP_IDLE;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      psr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = psr_pkg::OP_LOAD;
          state_d  = psr_pkg::ST_START;
        end
      end
      psr_pkg::ST_START: begin
        if (status_i.brake) begin
          cmd_o.op = psr_pkg::OP_MUL_M;
          state_d  = psr_pkg::ST_DIV_A;
        end else begin
          cmd_o.op = psr_pkg::OP_DIV_A;
          state_d  = psr_pkg::ST_DIV_B;
        end
      end
      psr_pkg::ST_DIV_A: begin
        cmd_o.op = psr_pkg::OP_DIV_A;
        state_d  = psr_pkg::ST_DIV_B;
      end
      psr_pkg::ST_DIV_B: begin
        cmd_o.op = psr_pkg::OP_DIV_B;
        state_d  = status_i.brake ? psr_pkg::ST_MUL_K : psr_pkg::ST_DELTA;
      end
      psr_pkg::ST_DELTA: begin
        cmd_o.op = psr_pkg::OP_DELTA;
        state_d  = psr_pkg::ST_MUL_K;
      end
      psr_pkg::ST_MUL_K: begin
        cmd_o.op = psr_pkg::OP_MUL_K;
        state_d  = psr_pkg::ST_MUL_LO;
      end
      psr_pkg::ST_MUL_LO: begin
        cmd_o.op = psr_pkg::OP_MUL_LO;
        state_d  = psr_pkg::ST_MUL_HI;
      end
      psr_pkg::ST_MUL_HI: begin
        cmd_o.op = psr_pkg::OP_MUL_HI;
        state_d  = psr_pkg::ST_UPDATE;
      end
      psr_pkg::ST_UPDATE: begin
        cmd_o.op = psr_pkg::OP_UPDATE;
        state_d  = psr_pkg::ST_OUT;
      end
      psr_pkg::ST_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = psr_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = psr_pkg::ST_IDLE;
        end
      end
      default: state_d = psr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != psr_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/pedal_speed_ramp_controller_unit.sv @@
// Top level of the pedal speed ramp controller.
// The result is registered at the end of the controller's pass, which waits in ST_OUT
// until the output register has been emptied.
// A new transaction is taken only once the pass is back in idle; the pass runs through
// the two-step divide by 1023 and three to four uses of the shared 24x17 multiplier.
// Reset (asynchronous, active low): speed clears, registers take defaults, no result pending.
module pedal_speed_ramp_controller_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [psr_pkg::RawW-1:0]     accel_raw_i,
  input  logic [psr_pkg::RawW-1:0]     brake_raw_i,
  input  logic [psr_pkg::RawW-1:0]     elapsed_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [psr_pkg::PotW-1:0]     pot_value_o,
  output logic [psr_pkg::SpeedW-1:0]   speed_now_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [psr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psr_pkg::CfgDatW-1:0]  cfg_data_i
);

  psr_pkg::psr_cfg_t    cfg;
  psr_pkg::psr_cmd_t    cmd;
  psr_pkg::psr_status_t status;

  psr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  psr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psr_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_i        (cfg),
    .accel_raw_i  (accel_raw_i),
    .brake_raw_i  (brake_raw_i),
    .elapsed_ms_i (elapsed_ms_i),
    .pot_value_o  (pot_value_o),
    .speed_now_o  (speed_now_o)
  );

endmodule

@@ hw/rtl/psr_checker.sv @@
// Port-level checks for the pedal speed ramp controller, bound to the top level.
module psr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [psr_pkg::PotW-1:0]    pot_value_o,
  input logic [psr_pkg::SpeedW-1:0]  speed_now_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pot_value_o) && $stable(speed_now_o))
    else $error("stalled result changed");

  // Speed never leaves its range
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_now_o <= psr_pkg::SpeedMax)
    else $error("speed above full scale");

  // Standstill maps to the idle wiper position
  a_zero_pot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speed_now_o == '0 |-> pot_value_o == 8'hFF)
    else $error("zero speed gave wrong wiper value");

  // Full speed maps to the end wiper position
  a_full_pot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speed_now_o == psr_pkg::SpeedMax |-> pot_value_o == 8'h00)
    else $error("full speed gave wrong wiper value");

  // Busy after taking a transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while working");

endmodule

bind pedal_speed_ramp_controller_unit psr_checker u_psr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pot_value_o (pot_value_o),
  .speed_now_o (speed_now_o)
);
